// ===== rtl/ies_pkg.sv =====
package ies_pkg;

   localparam int StackDepth = 1024;
   localparam int AddrWidth = 10;
   localparam int DepthWidth = 11;
   localparam int DataWidth = 32;

   typedef enum logic [2:0] {
      KIND_PUSH = 3'd0,
      KIND_POP = 3'd1,
      KIND_ADD = 3'd2,
      KIND_SUB = 3'd3,
      KIND_MUL = 3'd4,
      KIND_DIV = 3'd5,
      KIND_PEEK_TOP = 3'd6,
      KIND_PEEK_BOTTOM = 3'd7
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0,
      ST_FULL = 3'd1,
      ST_EMPTY = 3'd2,
      ST_FEW = 3'd3,
      ST_DIVZERO = 3'd4,
      ST_BADIDX = 3'd5
   } status_type;

   // One queued command between the front and back parts.
   typedef struct packed {
      logic [2:0] kind;
      logic [DataWidth-1:0] value;
      logic [AddrWidth-1:0] index;
   } cmd_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD1,
      S_RD2,
      S_WAIT,
      S_EXEC,
      S_MUL,
      S_DIV,
      S_DIVFIX,
      S_WRITE,
      S_OUT
   } state_type;

   // Divider control between the back part and the divide unit.
   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctl_type;

endpackage

// ===== rtl/ies_front.sv =====
module ies_front (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [2:0] req_kind,
   input  logic signed [31:0] req_push_value,
   input  logic [9:0] req_peek_index,
   output logic cmd_valid,
   input  logic cmd_take,
   output ies_pkg::cmd_type cmd
);

   // Two-entry command queue.
   ies_pkg::cmd_type q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic rd_ff, rd_in, wr_ff, wr_in;
   logic push_q, pop_q;

   assign req_stall = (cnt_ff == 2'd2);
   assign push_q = req_valid && !req_stall;
   assign pop_q = cmd_valid && cmd_take;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd = q_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push_q} - {1'b0, pop_q};
      wr_in = wr_ff ^ push_q;
      rd_in = rd_ff ^ pop_q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff <= rd_in;
         wr_ff <= wr_in;
      end
      if (push_q) begin
         q_ff[wr_ff] <= '{kind: req_kind, value: req_push_value, index: req_peek_index};
      end
   end

endmodule

// ===== rtl/ies_divider.sv =====
module ies_divider (
   input  logic clock,
   input  logic reset,
   input  ies_pkg::div_ctl_type ctl_in,
   output ies_pkg::div_ctl_type ctl_out,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic [31:0] quotient,
   output logic [31:0] remainder
);

   // Restoring unsigned divider, one quotient bit per cycle.
   logic [31:0] q_ff, q_in, r_ff, r_in;
   logic [5:0] step_ff, step_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [32:0] trial;

   assign ctl_out = '{start: 1'b0, busy: busy_ff, done: done_ff};
   assign quotient = q_ff;
   assign remainder = r_ff;

   always_comb begin
      trial = {r_ff, q_ff[31]} - {1'b0, divisor};
      q_in = q_ff;
      r_in = r_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl_in.start) begin
         q_in = dividend;
         r_in = '0;
         step_in = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial[32]) begin
            r_in = {r_ff[30:0], q_ff[31]};
            q_in = {q_ff[30:0], 1'b0};
         end else begin
            r_in = trial[31:0];
            q_in = {q_ff[30:0], 1'b1};
         end
         step_in = step_ff + 6'd1;
         if (step_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
   end

endmodule

// ===== rtl/ies_back.sv =====
module ies_back (
   input  logic clock,
   input  logic reset,
   input  logic cmd_valid,
   output logic cmd_take,
   input  ies_pkg::cmd_type cmd,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [31:0] rsp_result_value,
   output logic [2:0] rsp_status,
   output logic [10:0] rsp_depth
);

   ies_pkg::state_type state_ff, state_in;
   ies_pkg::cmd_type cur_ff;
   logic [31:0] mem [ies_pkg::StackDepth];
   logic [31:0] rd_data_ff;
   logic [9:0] rd_addr;
   logic rd_en;
   logic [9:0] wr_addr;
   logic wr_en;
   logic [10:0] depth_ff, depth_in;
   logic [31:0] rgt_ff, lft_ff, res_ff, res_in;
   logic [2:0] st_ff, st_in;
   logic [10:0] out_depth_ff;
   logic [31:0] out_res_ff;
   logic [2:0] out_st_ff;
   logic out_valid_ff;
   logic [31:0] prod_ff;
   logic [31:0] abs_l, abs_r;
   logic neg_q;
   ies_pkg::div_ctl_type dctl_in, dctl_out;
   logic [31:0] quo, rem;
   logic [31:0] q_signed;
   logic ok_in, ok_ff;

   assign rsp_valid = out_valid_ff;
   assign rsp_result_value = out_res_ff;
   assign rsp_status = out_st_ff;
   assign rsp_depth = out_depth_ff;
   assign cmd_take = (state_ff == ies_pkg::S_IDLE) && cmd_valid;

   assign abs_l = lft_ff[31] ? (~lft_ff + 32'd1) : lft_ff;
   assign abs_r = rgt_ff[31] ? (~rgt_ff + 32'd1) : rgt_ff;
   assign neg_q = lft_ff[31] ^ rgt_ff[31];
   // The divider starts only for a divide that has both operands and a nonzero divisor.
   assign dctl_in = '{start: (state_ff == ies_pkg::S_EXEC)
                      && (cur_ff.kind == ies_pkg::KIND_DIV) && ok_in,
                      busy: 1'b0, done: 1'b0};

   ies_divider u_div (
      .clock(clock), .reset(reset), .ctl_in(dctl_in), .ctl_out(dctl_out),
      .dividend(abs_l), .divisor(abs_r), .quotient(quo), .remainder(rem)
   );

   // Floor correction: negative quotient with a nonzero remainder steps down.
   assign q_signed = neg_q ? ((~quo + 32'd1) - {31'd0, rem != '0}) : quo;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ies_pkg::S_IDLE: if (cmd_valid) state_in = ies_pkg::S_RD1;
         ies_pkg::S_RD1: state_in = ies_pkg::S_RD2;
         ies_pkg::S_RD2: state_in = ies_pkg::S_WAIT;
         ies_pkg::S_WAIT: state_in = ies_pkg::S_EXEC;
         ies_pkg::S_EXEC: begin
            if (!ok_in) state_in = ies_pkg::S_OUT;
            else if (cur_ff.kind == ies_pkg::KIND_MUL) state_in = ies_pkg::S_MUL;
            else if (cur_ff.kind == ies_pkg::KIND_DIV) state_in = ies_pkg::S_DIV;
            else state_in = ies_pkg::S_WRITE;
         end
         ies_pkg::S_MUL: state_in = ies_pkg::S_WRITE;
         ies_pkg::S_DIV: if (dctl_out.done) state_in = ies_pkg::S_DIVFIX;
         ies_pkg::S_DIVFIX: state_in = ies_pkg::S_WRITE;
         ies_pkg::S_WRITE: state_in = ies_pkg::S_OUT;
         ies_pkg::S_OUT: if (!out_valid_ff || !rsp_stall) state_in = ies_pkg::S_IDLE;
         default: state_in = ies_pkg::S_IDLE;
      endcase
   end

   // Memory read address: first read fetches the top (or peek target),
   // second read fetches the entry below the top.
   always_comb begin
      rd_en = 1'b0;
      rd_addr = depth_ff[9:0] - 10'd1;
      case (state_ff)
         ies_pkg::S_RD1: begin
            rd_en = 1'b1;
            if (cur_ff.kind == ies_pkg::KIND_PEEK_TOP)
               rd_addr = depth_ff[9:0] - cur_ff.index - 10'd1;
            else if (cur_ff.kind == ies_pkg::KIND_PEEK_BOTTOM)
               rd_addr = cur_ff.index;
         end
         ies_pkg::S_RD2: begin
            rd_en = 1'b1;
            rd_addr = depth_ff[9:0] - 10'd2;
         end
         default: rd_en = 1'b0;
      endcase
   end

   // Outcome of the operation decided at execute; later states load the product or quotient and write the result.
   always_comb begin
      ok_in = 1'b1;
      st_in = ies_pkg::ST_OK;
      res_in = res_ff;
      depth_in = depth_ff;
      wr_en = 1'b0;
      wr_addr = depth_ff[9:0];
      case (state_ff)
         ies_pkg::S_EXEC: begin
            res_in = '0;
            case (cur_ff.kind)
               ies_pkg::KIND_PUSH: begin
                  if (depth_ff == 11'(ies_pkg::StackDepth)) st_in = ies_pkg::ST_FULL;
               end
               ies_pkg::KIND_POP: begin
                  if (depth_ff == '0) st_in = ies_pkg::ST_EMPTY;
                  else begin
                     res_in = rgt_ff;
                     depth_in = depth_ff - 11'd1;
                  end
               end
               ies_pkg::KIND_PEEK_TOP, ies_pkg::KIND_PEEK_BOTTOM: begin
                  if ({1'b0, cur_ff.index} < depth_ff) res_in = rgt_ff;
                  else st_in = ies_pkg::ST_BADIDX;
               end
               default: begin
                  if (depth_ff < 11'd2) st_in = ies_pkg::ST_FEW;
                  else begin
                     depth_in = depth_ff - 11'd2;
                     case (cur_ff.kind)
                        ies_pkg::KIND_ADD: res_in = lft_ff + rgt_ff;
                        ies_pkg::KIND_SUB: res_in = lft_ff - rgt_ff;
                        default: res_in = '0;
                     endcase
                     if (cur_ff.kind == ies_pkg::KIND_DIV && rgt_ff == '0)
                        st_in = ies_pkg::ST_DIVZERO;
                  end
               end
            endcase
            ok_in = (st_in == ies_pkg::ST_OK) && (cur_ff.kind != ies_pkg::KIND_POP)
                    && (cur_ff.kind != ies_pkg::KIND_PEEK_TOP)
                    && (cur_ff.kind != ies_pkg::KIND_PEEK_BOTTOM);
         end
         ies_pkg::S_MUL: begin
            st_in = st_ff;
            ok_in = ok_ff;
            res_in = prod_ff;
         end
         ies_pkg::S_DIVFIX: begin
            st_in = st_ff;
            ok_in = ok_ff;
            res_in = q_signed;
         end
         ies_pkg::S_WRITE: begin
            st_in = st_ff;
            ok_in = ok_ff;
            wr_en = 1'b1;
            depth_in = depth_ff + 11'd1;
         end
         default: begin
            st_in = st_ff;
            ok_in = ok_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ies_pkg::S_IDLE;
         depth_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         depth_ff <= depth_in;
         if (state_ff == ies_pkg::S_OUT && (!out_valid_ff || !rsp_stall))
            out_valid_ff <= 1'b1;
         else if (!rsp_stall)
            out_valid_ff <= 1'b0;
      end
      // Memory ports.
      if (rd_en) rd_data_ff <= mem[rd_addr];
      if (wr_en) mem[wr_addr] <= (cur_ff.kind == ies_pkg::KIND_PUSH) ? cur_ff.value : res_ff;
      // Operand capture.
      if (cmd_take) cur_ff <= cmd;
      if (state_ff == ies_pkg::S_RD2) rgt_ff <= rd_data_ff;
      if (state_ff == ies_pkg::S_WAIT) lft_ff <= rd_data_ff;
      prod_ff <= lft_ff * rgt_ff;
      res_ff <= res_in;
      st_ff <= st_in;
      ok_ff <= ok_in;
      if (state_ff == ies_pkg::S_OUT && (!out_valid_ff || !rsp_stall)) begin
         out_res_ff <= (cur_ff.kind == ies_pkg::KIND_PUSH) ? 32'd0 : res_ff;
         out_st_ff <= st_ff;
         out_depth_ff <= depth_ff;
      end
   end

endmodule

// ===== rtl/integer_evaluation_stack.sv =====
// Integer evaluation stack for postfix arithmetic, 1024 entries of 32 bits.
// The req_ channel carries one operation per transfer: req_kind selects
// push, pop, add, subtract, multiply, divide, peek top or peek bottom, with
// req_push_value and req_peek_index as operands. The rsp_ channel returns
// one transfer per operation with the value, a status code and the depth
// after the operation, in request order.
// A two-entry command queue decouples request acceptance from execution.
// Each operation steps through two reads, a wait and execute; multiply and
// divide add their own states, and a successful push, add, subtract, multiply
// or divide ends with a stack write before the response is registered. Divide
// runs a radix-2 divider one quotient bit per cycle. One operation executes at
// a time, so a new operation starts only after the last one's response is registered.
// Reset (synchronous, active high) empties the stack and the queue; stack
// memory contents are not cleared and need no clearing pass.
// While rsp_stall is high the response holds and execution waits; the queue
// keeps accepting requests until its two entries are full, then req_stall
// rises.
module integer_evaluation_stack (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [2:0] req_kind,
   input  logic signed [31:0] req_push_value,
   input  logic [9:0] req_peek_index,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [31:0] rsp_result_value,
   output logic [2:0] rsp_status,
   output logic [10:0] rsp_depth
);

   logic cmd_valid, cmd_take;
   ies_pkg::cmd_type cmd;

   // Front part: accept and queue requests.
   ies_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_kind(req_kind), .req_push_value(req_push_value),
      .req_peek_index(req_peek_index), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
      .cmd(cmd)
   );

   // Back part: execute against the stack memory.
   ies_back u_back (
      .clock(clock), .reset(reset), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
      .cmd(cmd), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_result_value(rsp_result_value), .rsp_status(rsp_status),
      .rsp_depth(rsp_depth)
   );

endmodule

// ===== sim/testbench.sv =====
// Scoreboard: keeps a shadow stack and a queue of predicted responses.
class stack_scoreboard;
   logic [31:0] shadow [ies_pkg::StackDepth];
   int unsigned depth;
   logic [31:0] want_value [$];
   logic [2:0] want_status [$];
   logic [10:0] want_depth [$];
   int errors;
   int checked;

   function new();
      depth = 0;
      errors = 0;
      checked = 0;
   endfunction

   // Floor division on signed 32-bit operands, result wrapped to 32 bits.
   function logic [31:0] floor_quotient(logic [31:0] l, logic [31:0] r);
      longint n;
      longint d;
      longint q;
      longint m;
      n = longint'(signed'(l));
      d = longint'(signed'(r));
      q = n / d;
      m = n % d;
      if (m != 0 && ((m < 0) != (d < 0))) q = q - 1;
      return q[31:0];
   endfunction

   // Predict the response for one accepted request.
   function void note_request(logic [2:0] kind, logic [31:0] val, logic [9:0] idx);
      logic [31:0] res;
      logic [31:0] lft;
      logic [31:0] rgt;
      logic [63:0] prod;
      ies_pkg::status_type st;
      res = '0;
      st = ies_pkg::ST_OK;
      case (kind)
         ies_pkg::KIND_PUSH: begin
            if (depth < ies_pkg::StackDepth) begin
               shadow[depth] = val;
               depth++;
            end else st = ies_pkg::ST_FULL;
         end
         ies_pkg::KIND_POP: begin
            if (depth > 0) begin
               depth--;
               res = shadow[depth];
            end else st = ies_pkg::ST_EMPTY;
         end
         ies_pkg::KIND_ADD, ies_pkg::KIND_SUB, ies_pkg::KIND_MUL, ies_pkg::KIND_DIV: begin
            if (depth < 2) st = ies_pkg::ST_FEW;
            else begin
               rgt = shadow[depth-1];
               lft = shadow[depth-2];
               depth -= 2;
               if (kind == ies_pkg::KIND_ADD) res = lft + rgt;
               else if (kind == ies_pkg::KIND_SUB) res = lft - rgt;
               else if (kind == ies_pkg::KIND_MUL) begin
                  prod = {32'd0, lft} * {32'd0, rgt};
                  res = prod[31:0];
               end else if (rgt == 0) st = ies_pkg::ST_DIVZERO;
               else res = floor_quotient(lft, rgt);
               if (st == ies_pkg::ST_OK) begin
                  shadow[depth] = res;
                  depth++;
               end
            end
         end
         default: begin
            if (idx < depth) begin
               if (kind == ies_pkg::KIND_PEEK_TOP) res = shadow[depth-idx-1];
               else res = shadow[idx];
            end else st = ies_pkg::ST_BADIDX;
         end
      endcase
      want_value.push_back(res);
      want_status.push_back(st);
      want_depth.push_back(depth[10:0]);
   endfunction

   // Compare one response transfer against the oldest prediction.
   function void check_response(logic [31:0] v, logic [2:0] s, logic [10:0] d);
      if (want_value.size() == 0) begin
         $display("%0t: unexpected response value=%h status=%0d depth=%0d", $time, v, s, d);
         errors++;
         return;
      end
      if (v !== want_value[0]) begin
         $display("%0t: value expected %h actual %h", $time, want_value[0], v);
         errors++;
      end
      if (s !== want_status[0]) begin
         $display("%0t: status expected %0d actual %0d", $time, want_status[0], s);
         errors++;
      end
      if (d !== want_depth[0]) begin
         $display("%0t: depth expected %0d actual %0d", $time, want_depth[0], d);
         errors++;
      end
      void'(want_value.pop_front());
      void'(want_status.pop_front());
      void'(want_depth.pop_front());
      checked++;
   endfunction
endclass

module testbench;
   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [2:0] req_kind;
   logic signed [31:0] req_push_value;
   logic [9:0] req_peek_index;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [31:0] rsp_result_value;
   logic [2:0] rsp_status;
   logic [10:0] rsp_depth;

   stack_scoreboard board;
   int cycles;
   int sent;
   int burst_left;
   int gap_left;
   int kind_count [8];
   localparam int CycleLimit = 400000;

   integer_evaluation_stack DUT (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      board = new();
      reset = 1;
      req_valid = 0;
      req_kind = '0;
      req_push_value = '0;
      req_peek_index = '0;
      rsp_stall = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;
   end

   // Sample both channels at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         cycles++;
         if (req_valid && !req_stall) begin
            board.note_request(req_kind, req_push_value, req_peek_index);
            kind_count[req_kind]++;
         end
         if (rsp_valid && !rsp_stall)
            board.check_response(rsp_result_value, rsp_status, rsp_depth);
         if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Receiver stall pattern: long stretches free, others stalling often.
   always @(negedge clock) begin
      if (reset) rsp_stall <= 0;
      else if ((cycles / 300) % 3 == 0) rsp_stall <= 0;
      else rsp_stall <= ($urandom_range(0, 99) < 40);
   end

   // Drive one request, after an idle gap between bursts, and hold it until a transfer happens.
   task automatic send_item(logic [2:0] k, logic [31:0] v, logic [9:0] i);
      if (gap_left > 0 && burst_left == 0) begin
         req_valid <= 0;
         repeat (gap_left) @(negedge clock);
         gap_left = 0;
      end
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
      req_valid <= 1;
      req_kind <= k;
      req_push_value <= v;
      req_peek_index <= i;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      burst_left--;
      sent++;
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 32'd0;
         4: return $urandom_range(0, 20) - 10;
         default: return $urandom();
      endcase
   endfunction

   initial begin
      int n;
      int target;
      logic [2:0] k;
      burst_left = 0;
      gap_left = 0;
      @(negedge clock);
      while (reset) @(negedge clock);

      // Directed: errors on empty stack, then the arithmetic corner cases.
      send_item(ies_pkg::KIND_POP, 0, 0);
      send_item(ies_pkg::KIND_ADD, 0, 0);
      send_item(ies_pkg::KIND_PEEK_TOP, 0, 0);
      send_item(ies_pkg::KIND_PEEK_BOTTOM, 0, 10'h3ff);
      send_item(ies_pkg::KIND_PUSH, 32'h8000_0000, 0);
      send_item(ies_pkg::KIND_DIV, 0, 0);
      send_item(ies_pkg::KIND_PUSH, 32'hffff_ffff, 0);
      send_item(ies_pkg::KIND_PEEK_TOP, 0, 1);
      send_item(ies_pkg::KIND_PEEK_BOTTOM, 0, 2);
      send_item(ies_pkg::KIND_DIV, 0, 0);
      send_item(ies_pkg::KIND_PUSH, -7, 0);
      send_item(ies_pkg::KIND_PUSH, 2, 0);
      send_item(ies_pkg::KIND_DIV, 0, 0);
      send_item(ies_pkg::KIND_PUSH, 7, 0);
      send_item(ies_pkg::KIND_PUSH, 32'h7fff_ffff, 0);
      send_item(ies_pkg::KIND_ADD, 0, 0);
      send_item(ies_pkg::KIND_PUSH, 32'h7fff_ffff, 0);
      send_item(ies_pkg::KIND_MUL, 0, 0);
      send_item(ies_pkg::KIND_PUSH, 32'h8000_0000, 0);
      send_item(ies_pkg::KIND_SUB, 0, 0);
      send_item(ies_pkg::KIND_PUSH, 0, 0);
      send_item(ies_pkg::KIND_DIV, 0, 0);
      send_item(ies_pkg::KIND_POP, 0, 0);
      send_item(ies_pkg::KIND_POP, 0, 0);

      // Fill the stack to full, try one more push, peek at the far ends, then shrink it with pops and arithmetic.
      while (board.depth < ies_pkg::StackDepth)
         send_item(ies_pkg::KIND_PUSH, $urandom(), 0);
      send_item(ies_pkg::KIND_PUSH, $urandom(), 0);
      send_item(ies_pkg::KIND_PEEK_TOP, 0, 10'h3ff);
      send_item(ies_pkg::KIND_PEEK_BOTTOM, 0, 10'h3ff);
      send_item(ies_pkg::KIND_PEEK_BOTTOM, 0, 0);
      while (board.depth > 3)
         send_item(3'(ies_pkg::KIND_POP + $urandom_range(0, 4)), 0, 0);

      // Random mix biased toward well-formed postfix sequences.
      target = sent + 750;
      while (sent < target) begin
         n = $urandom_range(0, 99);
         if (n < 35 || board.depth < 2) k = ies_pkg::KIND_PUSH;
         else if (n < 80) k = 3'(ies_pkg::KIND_ADD + $urandom_range(0, 3));
         else if (n < 86) k = ies_pkg::KIND_POP;
         else k = ($urandom_range(0, 1)) ? ies_pkg::KIND_PEEK_TOP : ies_pkg::KIND_PEEK_BOTTOM;
         if ($urandom_range(0, 19) == 0) k = 3'($urandom_range(0, 7));
         send_item(k, rand_value(),
                   ($urandom_range(0, 9) == 0) ? 10'($urandom()) :
                   10'($urandom_range(0, board.depth + 1)));
      end
      req_valid <= 0;

      while (board.want_value.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("Sent %0d operations, %0d responses checked; divides %0d, multiplies %0d.",
               sent, board.checked, kind_count[ies_pkg::KIND_DIV],
               kind_count[ies_pkg::KIND_MUL]);
      $display("Covered full, empty, too few operands, divide by zero and bad index.");
      if (board.errors == 0 && board.want_value.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
